[rtl/blocking_message_queue_top_macros.svh]
// assertion macros shared by the checker
`ifndef BLOCKING_MESSAGE_QUEUE_TOP_MACROS_SVH
`define BLOCKING_MESSAGE_QUEUE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define BMQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define BMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/bmq_pkg.sv]
package bmq_pkg;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;

    localparam int unsigned CFG_W = 7;
    localparam int unsigned WORD_W = 32;

    typedef struct packed {
        logic [1:0]        status;
        logic              wake_valid;
        logic [WORD_W-1:0] wake_id;
        logic              double_wait;
        logic              rx_done;
    } t_pend;

endpackage

[rtl/blocking_message_queue_top.sv]
// a request's result is registered in the control's pending register, then in the output register
// throughput: one request per cycle while o_in_stall is low; the store has one port used at most once per request
// a receive reads the store at transfer; the word waits in the store's read register until the output register takes it
// reset (synchronous, active low) empties the queue, clears both waiters and sets length to MAX_DEPTH, at most 64
// a length write empties the queue and keeps waiters; no clearing pass is needed
module blocking_message_queue_top #(
    parameter int unsigned MAX_DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [bmq_pkg::CFG_W-1:0]  i_cfg_queue_length,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_operation,
    input  logic [bmq_pkg::WORD_W-1:0] i_message_value,
    input  logic                       i_blocking,
    input  logic [bmq_pkg::WORD_W-1:0] i_requester_id,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic [bmq_pkg::WORD_W-1:0] o_received_value,
    output logic                       o_wake_valid,
    output logic [bmq_pkg::WORD_W-1:0] o_wake_id,
    output logic                       o_double_wait
);
    import bmq_pkg::*;

    localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int unsigned LW = $clog2(MAX_DEPTH + 1);

    logic              pend_valid;
    logic              pend_take;
    t_pend             pend;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;

    bmq_ctrl #(
        .MAX_DEPTH (MAX_DEPTH),
        .AW        (AW),
        .LW        (LW)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_message_value    (i_message_value),
        .i_blocking         (i_blocking),
        .i_requester_id     (i_requester_id),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_queue_length (i_cfg_queue_length),
        .i_pend_take        (pend_take),
        .o_pend_valid       (pend_valid),
        .o_pend             (pend),
        .o_mem_we           (mem_we),
        .o_mem_re           (mem_re),
        .o_mem_addr         (mem_addr),
        .o_mem_wdata        (mem_wdata)
    );

    bmq_store #(
        .MAX_DEPTH (MAX_DEPTH),
        .AW        (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    bmq_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pend_valid     (pend_valid),
        .i_pend           (pend),
        .i_rdata          (mem_rdata),
        .o_pend_take      (pend_take),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_received_value (o_received_value),
        .o_wake_valid     (o_wake_valid),
        .o_wake_id        (o_wake_id),
        .o_double_wait    (o_double_wait)
    );

endmodule

[rtl/bmq_store.sv]
module bmq_store #(
    parameter int unsigned MAX_DEPTH = 64,
    parameter int unsigned AW = 6
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_addr,
    input  logic [bmq_pkg::WORD_W-1:0] i_wdata,
    output logic [bmq_pkg::WORD_W-1:0] o_rdata
);
    import bmq_pkg::*;

    logic [WORD_W-1:0] r_mem [MAX_DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bmq_ctrl.sv]
module bmq_ctrl #(
    parameter int unsigned MAX_DEPTH = 64,
    parameter int unsigned AW = 6,
    parameter int unsigned LW = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_operation,
    input  logic [bmq_pkg::WORD_W-1:0] i_message_value,
    input  logic                       i_blocking,
    input  logic [bmq_pkg::WORD_W-1:0] i_requester_id,
    input  logic                       i_cfg_wr_en,
    input  logic [bmq_pkg::CFG_W-1:0]  i_cfg_queue_length,
    input  logic                       i_pend_take,
    output logic                       o_pend_valid,
    output bmq_pkg::t_pend             o_pend,
    output logic                       o_mem_we,
    output logic                       o_mem_re,
    output logic [AW-1:0]              o_mem_addr,
    output logic [bmq_pkg::WORD_W-1:0] o_mem_wdata
);
    import bmq_pkg::*;

    localparam int unsigned LEN_RST = (MAX_DEPTH < 64) ? MAX_DEPTH : 64;

    logic [LW-1:0]     r_len, n_len;
    logic [AW-1:0]     r_head, n_head;
    logic [LW-1:0]     r_fill, n_fill;
    logic              r_snd_wv, n_snd_wv;
    logic [WORD_W-1:0] r_snd_wid, n_snd_wid;
    logic              r_rcv_wv, n_rcv_wv;
    logic [WORD_W-1:0] r_rcv_wid, n_rcv_wid;
    logic              r_pend_valid, n_pend_valid;
    t_pend             r_pend, n_pend;

    logic          accept;
    logic          is_send;
    logic          full;
    logic          empty;
    logic [LW:0]   slot_sum;
    logic [LW:0]   slot_wrap;
    logic [LW-1:0] head_inc;
    logic [AW-1:0] slot;

    function automatic logic [LW-1:0] clamp_len(input logic [CFG_W-1:0] v);
        logic [LW-1:0] res;
        if (v == '0) begin
            res = LW'(1);
        end else if (32'(v) > MAX_DEPTH) begin
            res = LW'(MAX_DEPTH);
        end else begin
            res = LW'(v);
        end
        return res;
    endfunction

    assign o_in_stall = r_pend_valid && !i_pend_take;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_send    = (i_operation == OP_SEND);
    assign full       = (r_fill == r_len);
    assign empty      = (r_fill == '0);

    // tail slot is (head + fill) mod length, head below length and fill at most length
    assign slot_sum  = {1'b0, LW'(r_head)} + {1'b0, r_fill};
    assign slot_wrap = (slot_sum >= {1'b0, r_len}) ? (slot_sum - {1'b0, r_len}) : slot_sum;
    assign slot      = slot_wrap[AW-1:0];
    assign head_inc  = LW'(r_head) + LW'(1);

    assign o_mem_we    = accept && is_send && !full;
    assign o_mem_re    = accept && !is_send && !empty;
    assign o_mem_addr  = is_send ? slot : r_head;
    assign o_mem_wdata = i_message_value;

    always_comb begin
        n_len        = r_len;
        n_head       = r_head;
        n_fill       = r_fill;
        n_snd_wv     = r_snd_wv;
        n_snd_wid    = r_snd_wid;
        n_rcv_wv     = r_rcv_wv;
        n_rcv_wid    = r_rcv_wid;
        n_pend_valid = r_pend_valid && !i_pend_take;
        n_pend       = r_pend;

        priority if (i_cfg_wr_en) begin
            n_len  = clamp_len(i_cfg_queue_length);
            n_head = '0;
            n_fill = '0;
        end else if (accept) begin
            n_pend_valid       = 1'b1;
            n_pend.status      = ST_DONE;
            n_pend.wake_valid  = 1'b0;
            n_pend.wake_id     = '0;
            n_pend.double_wait = 1'b0;
            n_pend.rx_done     = 1'b0;
            if (is_send) begin
                if (full) begin
                    if (!i_blocking) begin
                        n_pend.status = ST_REFUSED;
                    end else begin
                        n_pend.status      = ST_BLOCKED;
                        n_pend.double_wait = r_snd_wv;
                        n_snd_wv           = 1'b1;
                        n_snd_wid          = i_requester_id;
                    end
                end else begin
                    n_fill = r_fill + LW'(1);
                    if (r_rcv_wv) begin
                        n_pend.wake_valid = 1'b1;
                        n_pend.wake_id    = r_rcv_wid;
                        n_rcv_wv          = 1'b0;
                        n_rcv_wid         = '0;
                    end
                end
            end else begin
                if (empty) begin
                    if (!i_blocking) begin
                        n_pend.status = ST_REFUSED;
                    end else begin
                        n_pend.status      = ST_BLOCKED;
                        n_pend.double_wait = r_rcv_wv;
                        n_rcv_wv           = 1'b1;
                        n_rcv_wid          = i_requester_id;
                    end
                end else begin
                    n_pend.rx_done = 1'b1;
                    n_head = (head_inc == r_len) ? '0 : head_inc[AW-1:0];
                    n_fill = r_fill - LW'(1);
                    if (r_snd_wv) begin
                        n_pend.wake_valid = 1'b1;
                        n_pend.wake_id    = r_snd_wid;
                        n_snd_wv          = 1'b0;
                        n_snd_wid         = '0;
                    end
                end
            end
        end else begin
            n_len = r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= LW'(LEN_RST);
            r_head       <= '0;
            r_fill       <= '0;
            r_snd_wv     <= 1'b0;
            r_snd_wid    <= '0;
            r_rcv_wv     <= 1'b0;
            r_rcv_wid    <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_len        <= n_len;
            r_head       <= n_head;
            r_fill       <= n_fill;
            r_snd_wv     <= n_snd_wv;
            r_snd_wid    <= n_snd_wid;
            r_rcv_wv     <= n_rcv_wv;
            r_rcv_wid    <= n_rcv_wid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    assign o_pend_valid = r_pend_valid;
    assign o_pend       = r_pend;

endmodule

[rtl/bmq_out.sv]
module bmq_out (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_pend_valid,
    input  bmq_pkg::t_pend             i_pend,
    input  logic [bmq_pkg::WORD_W-1:0] i_rdata,
    output logic                       o_pend_take,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic [bmq_pkg::WORD_W-1:0] o_received_value,
    output logic                       o_wake_valid,
    output logic [bmq_pkg::WORD_W-1:0] o_wake_id,
    output logic                       o_double_wait
);
    import bmq_pkg::*;

    logic              r_valid, n_valid;
    logic [1:0]        r_status;
    logic [WORD_W-1:0] r_rx_value;
    logic              r_wake_valid;
    logic [WORD_W-1:0] r_wake_id;
    logic              r_double_wait;
    logic              take;

    assign take        = i_pend_valid && (!r_valid || !i_out_stall);
    assign o_pend_take = take;

    always_comb begin
        n_valid = r_valid && i_out_stall;
        if (take) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // popped word comes from the store's read register, loaded at the read
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status      <= i_pend.status;
            r_rx_value    <= i_pend.rx_done ? i_rdata : '0;
            r_wake_valid  <= i_pend.wake_valid;
            r_wake_id     <= i_pend.wake_id;
            r_double_wait <= i_pend.double_wait;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_status         = r_status;
    assign o_received_value = r_rx_value;
    assign o_wake_valid     = r_wake_valid;
    assign o_wake_id        = r_wake_id;
    assign o_double_wait    = r_double_wait;

endmodule

[rtl/bmq_checker.sv]
`include "blocking_message_queue_top_macros.svh"

module bmq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [1:0]                 o_status,
    input logic [bmq_pkg::WORD_W-1:0] o_received_value,
    input logic                       o_wake_valid,
    input logic [bmq_pkg::WORD_W-1:0] o_wake_id,
    input logic                       o_double_wait
);
    import bmq_pkg::*;

    // only a blocked request can replace a waiter
    `BMQ_ASSERT_NOW(a_dbl_only_blocked, i_clk, i_rst_n, o_out_valid && o_double_wait, o_status == ST_BLOCKED)

    // a refused or blocked request wakes nobody and pops nothing
    `BMQ_ASSERT_NOW(a_fail_quiet, i_clk, i_rst_n, o_out_valid && (o_status != ST_DONE), !o_wake_valid && (o_received_value == '0))

    // no wake id without a wake
    `BMQ_ASSERT_NOW(a_wake_id_zero, i_clk, i_rst_n, o_out_valid && !o_wake_valid, o_wake_id == '0)

    // a stalled result stays put
    `BMQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_received_value) && $stable(o_wake_id))

endmodule

bind blocking_message_queue_top bmq_checker u_bmq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_received_value (o_received_value),
    .o_wake_valid     (o_wake_valid),
    .o_wake_id        (o_wake_id),
    .o_double_wait    (o_double_wait)
);

[dv/blocking_message_queue_top_tb.sv]
module blocking_message_queue_top_tb;

    import bmq_pkg::*;

    localparam int unsigned DEPTH = 64;
    localparam int unsigned N_PHASES = 14;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] word;
        logic              blk;
        logic [WORD_W-1:0] who;
    } t_mbox_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] rx_word;
        logic              wake;
        logic [WORD_W-1:0] wake_who;
        logic              dbl;
    } t_mbox_outcome;

    typedef enum logic [1:0] {
        PH_IDLING,
        PH_STEADY,
        PH_STRESS
    } t_phase_kind;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]  cfg_queue_length = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              op = OP_SEND;
    logic [WORD_W-1:0] msg_value = '0;
    logic              blocking = 1'b0;
    logic [WORD_W-1:0] requester_id = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        status;
    logic [WORD_W-1:0] rx_value;
    logic              wake_valid;
    logic [WORD_W-1:0] wake_id;
    logic              double_wait;

    // mailbox shadow state
    logic [WORD_W-1:0] msg_store [DEPTH];
    logic [5:0]        q_head = '0;
    logic [6:0]        q_fill = '0;
    logic [CFG_W-1:0]  q_length = 7'd64;
    logic              snd_wait_vld = 1'b0;
    logic [WORD_W-1:0] snd_wait_id = '0;
    logic              rcv_wait_vld = 1'b0;
    logic [WORD_W-1:0] rcv_wait_id = '0;

    t_mbox_req     queued_requests [$];
    t_mbox_outcome awaited_outcomes [$];
    int unsigned   fail_count = 0;

    logic        send_idle = 1'b1;
    logic        rx_idle = 1'b1;
    logic        stress_on = 1'b0;
    int unsigned send_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned hold_left = 0;
    logic        long_hold_done = 1'b0;

    int unsigned phase_len [N_PHASES] = '{5, 64, 2, 1, 3, 127, 9, 0, 65, 4, 16, 7, 2, 6};
    int unsigned phase_cnt [N_PHASES] =
        '{80, 260, 80, 80, 80, 140, 80, 80, 140, 80, 80, 80, 80, 80};
    t_phase_kind phase_kind [N_PHASES] = '{PH_IDLING, PH_IDLING, PH_IDLING, PH_IDLING,
        PH_STRESS, PH_IDLING, PH_STEADY, PH_IDLING, PH_IDLING, PH_IDLING, PH_IDLING,
        PH_IDLING, PH_STEADY, PH_STEADY};

    blocking_message_queue_top #(
        .MAX_DEPTH(DEPTH)
    ) i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_queue_length (cfg_queue_length),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_operation        (op),
        .i_message_value    (msg_value),
        .i_blocking         (blocking),
        .i_requester_id     (requester_id),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_status           (status),
        .o_received_value   (rx_value),
        .o_wake_valid       (wake_valid),
        .o_wake_id          (wake_id),
        .o_double_wait      (double_wait)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_mbox_outcome mailbox_outcome(input t_mbox_req r);
        t_mbox_outcome res;
        int unsigned   len;
        int unsigned   slot;
        res = '0;
        len = (q_length == 0) ? 1 : ((q_length > DEPTH) ? DEPTH : q_length);
        if (q_head >= len) q_head = '0;
        if (q_fill > len) q_fill = 7'(len);
        res.status = ST_DONE;
        if (r.op == OP_SEND) begin
            if (q_fill >= len) begin
                if (!r.blk) begin
                    res.status = ST_REFUSED;
                end else begin
                    res.dbl = snd_wait_vld;
                    snd_wait_vld = 1'b1;
                    snd_wait_id = r.who;
                    res.status = ST_BLOCKED;
                end
            end else begin
                slot = (q_head + q_fill) % len;
                msg_store[slot] = r.word;
                q_fill = q_fill + 1'b1;
                if (rcv_wait_vld) begin
                    res.wake = 1'b1;
                    res.wake_who = rcv_wait_id;
                    rcv_wait_vld = 1'b0;
                    rcv_wait_id = '0;
                end
            end
        end else begin
            if (q_fill == 0) begin
                if (!r.blk) begin
                    res.status = ST_REFUSED;
                end else begin
                    res.dbl = rcv_wait_vld;
                    rcv_wait_vld = 1'b1;
                    rcv_wait_id = r.who;
                    res.status = ST_BLOCKED;
                end
            end else begin
                res.rx_word = msg_store[q_head];
                q_head = 6'((q_head + 1) % len);
                q_fill = q_fill - 1'b1;
                if (snd_wait_vld) begin
                    res.wake = 1'b1;
                    res.wake_who = snd_wait_id;
                    snd_wait_vld = 1'b0;
                    snd_wait_id = '0;
                end
            end
        end
        return res;
    endfunction

    function automatic void add_req(input logic o, input logic [WORD_W-1:0] w,
                                    input logic b, input logic [WORD_W-1:0] id);
        t_mbox_req r;
        r.op = o;
        r.word = w;
        r.blk = b;
        r.who = id;
        queued_requests.push_back(r);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return WORD_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (queued_requests.size() != 0 || in_valid || awaited_outcomes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_queue_length <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        q_length = v;
        q_head = '0;
        q_fill = '0;
    endtask

    // sender
    always @(posedge clk) begin : sender
        t_mbox_req nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || !in_stall) begin
            if (send_gap != 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (queued_requests.size() != 0) begin
                nxt = queued_requests.pop_front();
                in_valid <= 1'b1;
                op <= nxt.op;
                msg_value <= nxt.word;
                blocking <= nxt.blk;
                requester_id <= nxt.who;
                if (send_idle && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 11);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off during the stress phase
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_gap <= 0;
            hold_left <= 0;
            long_hold_done <= 1'b0;
        end else if (stress_on && !long_hold_done) begin
            out_stall <= 1'b1;
            hold_left <= 300;
            long_hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (rx_gap != 0) begin
            out_stall <= 1'b1;
            rx_gap <= rx_gap - 1;
        end else if (rx_idle && $urandom_range(0, 7) == 0) begin
            out_stall <= 1'b1;
            rx_gap <= $urandom_range(0, 10);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin : monitor
        t_mbox_req     req;
        t_mbox_outcome want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                req.op = op;
                req.word = msg_value;
                req.blk = blocking;
                req.who = requester_id;
                awaited_outcomes.push_back(mailbox_outcome(req));
            end
            if (out_valid && !out_stall) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    fail_count++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    check_field("status", WORD_W'(want.status), WORD_W'(status));
                    check_field("received_value", want.rx_word, rx_value);
                    check_field("wake_valid", WORD_W'(want.wake), WORD_W'(wake_valid));
                    check_field("wake_id", want.wake_who, wake_id);
                    check_field("double_wait", WORD_W'(want.dbl), WORD_W'(double_wait));
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("** blocking_message_queue_top: FAILED **");
        $finish;
    end

    initial begin
        int unsigned p;
        int unsigned k;
        int unsigned eff;
        int unsigned chunk;
        logic        filling;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // length 64 from reset: empty queue, receive waiters, double wait
        add_req(OP_RECV, 32'h0, 1'b0, 32'h1);
        add_req(OP_RECV, 32'h0, 1'b1, 32'hFFFF_FFFF);
        add_req(OP_RECV, 32'h0, 1'b1, 32'h0);
        add_req(OP_SEND, 32'hFFFF_FFFF, 1'b0, 32'h1234_5678);
        add_req(OP_SEND, 32'h0, 1'b0, 32'h2);
        add_req(OP_SEND, 32'hA5A5_A5A5, 1'b1, 32'h3);
        add_req(OP_RECV, 32'h0, 1'b0, 32'h4);
        add_req(OP_RECV, 32'h0, 1'b1, 32'h5);
        add_req(OP_RECV, 32'h0, 1'b0, 32'h6);
        add_req(OP_RECV, 32'h0, 1'b1, 32'hDEAD_BEEF);
        wait_idle();

        // length 1: waiter kept over the write, full queue, send waiters
        write_length(7'd1);
        add_req(OP_SEND, 32'h1, 1'b0, 32'h8);
        add_req(OP_SEND, 32'h2, 1'b0, 32'h9);
        add_req(OP_SEND, 32'h3, 1'b1, 32'h7);
        add_req(OP_SEND, 32'h4, 1'b1, 32'hFFFF_FFFF);
        add_req(OP_RECV, 32'h0, 1'b0, 32'hA);
        add_req(OP_SEND, 32'h8000_0000, 1'b0, 32'hB);
        add_req(OP_SEND, 32'h5, 1'b1, 32'h3);
        wait_idle();

        // length 0 behaves as 1
        write_length(7'd0);
        add_req(OP_SEND, 32'h5, 1'b0, 32'hC);
        add_req(OP_SEND, 32'h6, 1'b0, 32'hD);
        add_req(OP_RECV, 32'h0, 1'b0, 32'hE);
        wait_idle();

        // length above the depth
        write_length(7'd127);
        add_req(OP_SEND, 32'h7FFF_FFFF, 1'b1, 32'hF);
        add_req(OP_RECV, 32'h0, 1'b0, 32'h10);
        add_req(OP_RECV, 32'h0, 1'b0, 32'h11);
        wait_idle();

        // random phases, swinging between filling and draining
        for (p = 0; p < N_PHASES; p++) begin
            write_length(CFG_W'(phase_len[p]));
            send_idle <= (phase_kind[p] == PH_IDLING);
            rx_idle <= (phase_kind[p] == PH_IDLING);
            stress_on <= (phase_kind[p] == PH_STRESS);
            eff = (phase_len[p] == 0) ? 1 : ((phase_len[p] > DEPTH) ? DEPTH : phase_len[p]);
            chunk = (eff >= 32) ? 120 : 2 * eff + 6;
            filling = 1'b0;
            for (k = 0; k < phase_cnt[p]; k++) begin
                if (k % chunk == 0) filling = !filling;
                add_req(($urandom_range(0, 99) < (filling ? 80 : 20)) ? OP_SEND : OP_RECV,
                        pick_word(), 1'($urandom_range(0, 1)), pick_word());
            end
            wait_idle();
            stress_on <= 1'b0;
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("** blocking_message_queue_top: PASSED **");
        end else begin
            $display("** blocking_message_queue_top: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/bmq_pkg.sv
rtl/bmq_store.sv
rtl/bmq_ctrl.sv
rtl/bmq_out.sv
rtl/blocking_message_queue_top.sv
rtl/bmq_checker.sv
dv/blocking_message_queue_top_tb.sv
